// File: rtl/core/egd_pkg.sv
// shared types and constants for the exp-golomb stream decoder
package egd_pkg;

  // bits in one stream byte and results one byte can give
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxRes = 8;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CntW   = 4;
  // prefix zero count and suffix counter width
  localparam int unsigned ZcW    = 6;
  // value width
  localparam int unsigned ValW   = 32;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // one decoded code: value plus one, i.e. a leading one followed by the suffix
  typedef struct packed {
    logic [ValW-1:0] vp1;
    status_e         status;
  } res_t;

  typedef res_t [MaxRes-1:0] res_bank_t;

  // code progress carried from byte to byte
  typedef struct packed {
    logic [ZcW-1:0]  zero_count;
    logic            in_suffix;
    logic [ZcW-1:0]  suffix_left;
    logic [ValW-1:0] acc;
  } code_state_t;

endpackage

// File: rtl/core/egd_decode.sv
// walks the eight bits of one byte and collects every finished code, plus a truncated one at end of data
module egd_decode #(
  parameter int unsigned MAX_PREFIX = 31
) (
  input  egd_pkg::code_state_t          state_i,
  input  logic [egd_pkg::ByteW-1:0]     byte_i,
  input  logic                          eod_i,
  output egd_pkg::code_state_t          state_o,
  output egd_pkg::res_bank_t            res_o,
  output logic [egd_pkg::CntW-1:0]      cnt_o
);

  // bit walk, msb first, one result at most per bit
  always_comb begin
    egd_pkg::code_state_t st;
    egd_pkg::res_bank_t   res;
    egd_pkg::res_t        hit_res;
    logic [egd_pkg::CntW-1:0] cnt;
    logic                 hit;
    logic                 bit_v;
    st  = state_i;
    res = '0;
    cnt = '0;
    for (int i = 0; i < int'(egd_pkg::ByteW); i++) begin
      hit     = 1'b0;
      hit_res = '0;
      bit_v   = byte_i[egd_pkg::ByteW-1-i];
      if (!st.in_suffix) begin
        if (!bit_v) begin
          st.zero_count = st.zero_count + 1'b1;
          if (st.zero_count > egd_pkg::ZcW'(MAX_PREFIX)) begin
            hit            = 1'b1;
            hit_res.status = egd_pkg::ST_OVERFLOW;
            st             = '0;
          end
        end else if (st.zero_count == '0) begin
          hit            = 1'b1;
          hit_res.vp1    = egd_pkg::ValW'(1);
          hit_res.status = egd_pkg::ST_OK;
          st             = '0;
        end else begin
          // leading one seeds the accumulator so it ends as value plus one
          st.in_suffix   = 1'b1;
          st.suffix_left = st.zero_count;
          st.acc         = egd_pkg::ValW'(1);
        end
      end else begin
        st.acc         = {st.acc[egd_pkg::ValW-2:0], bit_v};
        st.suffix_left = st.suffix_left - 1'b1;
        if (st.suffix_left == '0) begin
          hit            = 1'b1;
          hit_res.vp1    = st.acc;
          hit_res.status = egd_pkg::ST_OK;
          st             = '0;
        end
      end
      if (hit) begin
        res[cnt[egd_pkg::IdxW-1:0]] = hit_res;
        cnt = cnt + 1'b1;
      end
    end
    // unfinished code on the final byte
    if (eod_i) begin
      if ((st.in_suffix || st.zero_count != '0) && cnt < egd_pkg::CntW'(egd_pkg::MaxRes)) begin
        res[cnt[egd_pkg::IdxW-1:0]].vp1    = '0;
        res[cnt[egd_pkg::IdxW-1:0]].status = egd_pkg::ST_TRUNC;
        cnt = cnt + 1'b1;
      end
      st = '0;
    end
    state_o = st;
    res_o   = res;
    cnt_o   = cnt;
  end

endmodule

// File: rtl/core/exp_golomb_stream_decoder_unit.sv
// order-0 exp-golomb ue/se stream decoder, one byte per beat in, one code per beat out
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | sink      | in_valid_i / in_stall_o | data_byte_i, end_of_data_i
//   out     | source    | out_valid_o / out_stall_i | unsigned_value_o, signed_value_o,
//           |           |                        | status_o, last_o
//
// a byte is taken every cycle while it gives at most one result and the output is not stalled; a byte
// giving k results holds the input while the result bank (one byte's codes) drains one a cycle.
// an input beat's first result passes through the input, bank and output registers.
// reset clears the code progress, the bank count and pointer and all valid flags; no clearing pass is needed.
// a stall on the output holds the output register and backs up through bank and input.
module exp_golomb_stream_decoder_unit #(
  parameter int unsigned MAX_PREFIX = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                unsigned_value_o,
  output logic signed [31:0]         signed_value_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);

  // input register
  logic                          s1_valid_q, s1_valid_d;
  logic [egd_pkg::ByteW-1:0]     s1_byte_q;
  logic                          s1_eod_q;

  // code progress
  egd_pkg::code_state_t          code_q, code_d;

  // result bank
  egd_pkg::res_bank_t            bank_q, dec_res;
  logic [egd_pkg::CntW-1:0]      bank_cnt_q, bank_cnt_d, dec_cnt;
  logic [egd_pkg::IdxW-1:0]      bank_idx_q, bank_idx_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [egd_pkg::ValW-1:0]      uval_q, uval_d;
  logic [egd_pkg::ValW-1:0]      sval_q, sval_d;
  egd_pkg::status_e              status_q, status_d;
  logic                          last_q, last_d;

  logic in_accept, out_ready, pop, pop_last, bank_free, load;
  egd_pkg::res_t sel;
  logic [egd_pkg::ValW-1:0] half;

  egd_decode #(
    .MAX_PREFIX(MAX_PREFIX)
  ) u_decode (
    .state_i (code_q),
    .byte_i  (s1_byte_q),
    .eod_i   (s1_eod_q),
    .state_o (code_d),
    .res_o   (dec_res),
    .cnt_o   (dec_cnt)
  );

  // flow control between the stages
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign pop        = (bank_cnt_q != '0) && out_ready;
  assign pop_last   = pop && ({1'b0, bank_idx_q} == bank_cnt_q - 1'b1);
  assign bank_free  = (bank_cnt_q == '0) || pop_last;
  assign load       = s1_valid_q && bank_free;
  assign in_stall_o = s1_valid_q && !bank_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_accept ? 1'b1 : (load ? 1'b0 : s1_valid_q);

  // bank occupancy and read pointer
  always_comb begin
    bank_cnt_d = bank_cnt_q;
    bank_idx_d = bank_idx_q;
    if (load) begin
      bank_cnt_d = dec_cnt;
      bank_idx_d = '0;
    end else if (pop_last) begin
      bank_cnt_d = '0;
      bank_idx_d = '0;
    end else if (pop) begin
      bank_idx_d = bank_idx_q + 1'b1;
    end
  end

  // value and signed mapping from value plus one
  assign sel  = bank_q[bank_idx_q];
  assign half = sel.vp1 >> 1;

  always_comb begin
    out_valid_d = pop ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
    uval_d      = uval_q;
    sval_d      = sval_q;
    status_d    = status_q;
    last_d      = last_q;
    if (pop) begin
      status_d = sel.status;
      last_d   = pop_last;
      if (sel.status == egd_pkg::ST_OK) begin
        uval_d = sel.vp1 - 1'b1;
        sval_d = sel.vp1[0] ? (~half + 1'b1) : half;
      end else begin
        uval_d = '0;
        sval_d = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      code_q      <= '0;
      bank_cnt_q  <= '0;
      bank_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      bank_cnt_q  <= bank_cnt_d;
      bank_idx_q  <= bank_idx_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        code_q <= code_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_eod_q  <= end_of_data_i;
    end
    if (load) begin
      bank_q <= dec_res;
    end
    uval_q   <= uval_d;
    sval_q   <= sval_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign unsigned_value_o = uval_q;
  assign signed_value_o   = $signed(sval_q);
  assign status_o         = status_q;
  assign last_o           = last_q;

  // bank never holds more than one byte's worth of results
  a_bank_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_cnt_q <= egd_pkg::CntW'(egd_pkg::MaxRes))
    else $error("result bank count out of range");

  // read pointer stays inside the filled part of the bank
  a_bank_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_cnt_q != '0) |-> ({1'b0, bank_idx_q} < bank_cnt_q))
    else $error("bank read pointer past fill");

  // prefix count never passes its limit between bytes
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_q.zero_count <= egd_pkg::ZcW'(MAX_PREFIX))
    else $error("prefix count above limit");

  // a pending suffix has bits left, no more than the prefix length
  a_suffix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_q.in_suffix |-> (code_q.suffix_left != '0 &&
                          code_q.suffix_left <= code_q.zero_count))
    else $error("suffix counter inconsistent");

  // error beats carry zero values
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != egd_pkg::ST_OK) |-> (uval_q == '0 && sval_q == '0))
    else $error("error result with nonzero value");

endmodule
